// File: src/fwmu_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fwmu_pkg: shared types and constants of the mutex with FIFO wait queue
// Sizes of the wait ring, task id width, command and status codes and the
// packed item types of the request and result channels.
// ----------------------------------------------------------------------------
package fwmu_pkg;

  localparam int QUEUE_DEPTH  = 256;
  localparam int TASK_ID_BITS = 8;

  // fixed field widths of the channels
  localparam int CMD_W     = 2;
  localparam int TASK_W    = 8;
  localparam int STATUS_W  = 3;
  localparam int WTOTAL_W  = 9;

  // task id bits that count, ring address and fill count widths
  localparam int TID_W  = (TASK_ID_BITS < TASK_W) ? TASK_ID_BITS : TASK_W;
  localparam int ADDR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [CMD_W-1:0] {
    CMD_ACQUIRE = 2'd0,
    CMD_RELEASE = 2'd1,
    CMD_QUERY   = 2'd2
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_GRANTED  = 3'd0,
    ST_QUEUED   = 3'd1,
    ST_DROPPED  = 3'd2,
    ST_REJECTED = 3'd3,
    ST_RELEASED = 3'd4,
    ST_QUERIED  = 3'd5
  } status_t;

  typedef struct packed {
    logic [CMD_W-1:0]  command;
    logic [TASK_W-1:0] task_id;
  } fwmu_req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic                next_valid;
    logic [TASK_W-1:0]   deq_task;
    logic                was_owner;
    logic                is_waiting;
    logic [WTOTAL_W-1:0] waiting_total;
  } fwmu_res_t;

  // controller to datapath
  typedef struct packed {
    logic capture;       // latch the accepted item
    logic acquire;       // grant, queue or drop, and report
    logic reject;        // report a rejected release
    logic release_lock;  // free the lock, dequeue the head if any, read head
    logic rel_empty;     // report a release with no waiter
    logic rel_deq;       // report a release with the dequeued waiter
    logic scan_start;    // read the first queue entry
    logic scan_step;     // compare one entry, read the next
    logic query_done;    // report a query
    logic query_hit;     // query result
  } fwmu_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic op_acquire;
    logic op_release;
    logic was_owner;
    logic count_zero;
    logic scan_hit;
    logic scan_last;
  } fwmu_stat_t;

endpackage
`default_nettype wire

// File: src/fwmu_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fwmu_ram: generic single write port, single read port RAM
// One write and one read per cycle; read data is registered.
// ----------------------------------------------------------------------------
module fwmu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// File: src/fwmu_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fwmu_ctrl: sequencer of the mutex unit
// Takes one item at a time, decodes it and steps the datapath through
// acquire, release with dequeue, or a queue scan one entry per cycle.
// ----------------------------------------------------------------------------
module fwmu_ctrl import fwmu_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       start,
  output logic            busy,
  input  wire fwmu_stat_t stat,
  output fwmu_cmd_t       cmd
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_EXEC = 4'b0010,
    S_DEQ  = 4'b0100,
    S_SCAN = 4'b1000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.capture = 1'b1;
          state_next  = S_EXEC;
        end
      end
      S_EXEC: begin
        if (stat.op_acquire) begin
          cmd.acquire = 1'b1;
          state_next  = S_IDLE;
        end else if (stat.op_release) begin
          if (!stat.was_owner) begin
            cmd.reject = 1'b1;
            state_next = S_IDLE;
          end else begin
            cmd.release_lock = 1'b1;
            if (stat.count_zero) begin
              cmd.rel_empty = 1'b1;
              state_next    = S_IDLE;
            end else begin
              state_next = S_DEQ;
            end
          end
        end else if (stat.count_zero) begin
          cmd.query_done = 1'b1;
          state_next     = S_IDLE;
        end else begin
          cmd.scan_start = 1'b1;
          state_next     = S_SCAN;
        end
      end
      S_DEQ: begin
        cmd.rel_deq = 1'b1;
        state_next  = S_IDLE;
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (stat.scan_hit || stat.scan_last) begin
          cmd.query_done = 1'b1;
          cmd.query_hit  = stat.scan_hit;
          state_next     = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

// File: src/fwmu_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fwmu_dp: datapath of the mutex unit
// Lock and owner registers, the wait ring with its head and fill count,
// the scan index and the registered result.
// ----------------------------------------------------------------------------
module fwmu_dp import fwmu_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire fwmu_req_t request,
  input  wire fwmu_cmd_t cmd,
  output fwmu_stat_t     stat,
  output logic           done,
  output fwmu_res_t      result
);

  logic              lock_held;
  logic [TID_W-1:0]  owner_task;
  logic [ADDR_W-1:0] ring_head;
  logic [CNT_W-1:0]  ring_count;
  logic [ADDR_W-1:0] scan_idx;

  logic [CMD_W-1:0]  cmd_q;
  logic [TID_W-1:0]  tid_q;
  logic              owner_q;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [ADDR_W-1:0] ram_raddr;
  logic [TID_W-1:0]  ram_rdata;
  logic [TID_W-1:0]  tid_in;
  logic              count_full;
  logic [CNT_W-1:0]  count_dec;

  // head plus offset wrapped once into the ring
  function automatic logic [ADDR_W-1:0] ring_slot(input logic [ADDR_W-1:0] head,
                                                  input logic [CNT_W-1:0]  off);
    logic [CNT_W:0] sum;
    sum = (CNT_W+1)'(head) + (CNT_W+1)'(off);
    if (sum >= (CNT_W+1)'(QUEUE_DEPTH)) begin
      sum = sum - (CNT_W+1)'(QUEUE_DEPTH);
    end
    return sum[ADDR_W-1:0];
  endfunction

  assign tid_in     = request.task_id[TID_W-1:0];
  assign count_full = (ring_count == CNT_W'(QUEUE_DEPTH));
  assign count_dec  = ring_count - CNT_W'(1);

  assign ram_we    = cmd.acquire && lock_held && !count_full;
  assign ram_waddr = ring_slot(ring_head, ring_count);
  assign ram_raddr = cmd.scan_step ? ring_slot(ring_head, CNT_W'(scan_idx) + CNT_W'(1))
                                   : ring_head;

  fwmu_ram #(
    .WIDTH (TID_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (tid_q),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    stat.op_acquire = (cmd_q == CMD_ACQUIRE);
    stat.op_release = (cmd_q == CMD_RELEASE);
    stat.was_owner  = owner_q;
    stat.count_zero = (ring_count == '0);
    stat.scan_hit   = (ram_rdata == tid_q);
    stat.scan_last  = ((CNT_W'(scan_idx) + CNT_W'(1)) == ring_count);
  end

  // item latch and scan index
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cmd_q   <= request.command;
      tid_q   <= tid_in;
      owner_q <= lock_held && (owner_task == tid_in);
    end
    if (cmd.scan_start) begin
      scan_idx <= '0;
    end else if (cmd.scan_step) begin
      scan_idx <= scan_idx + ADDR_W'(1);
    end
  end

  // lock and ring state
  always_ff @(posedge clk) begin
    if (rst) begin
      lock_held  <= 1'b0;
      owner_task <= '0;
      ring_head  <= '0;
      ring_count <= '0;
    end else begin
      if (cmd.acquire) begin
        if (!lock_held) begin
          lock_held  <= 1'b1;
          owner_task <= tid_q;
        end else if (!count_full) begin
          ring_count <= ring_count + CNT_W'(1);
        end
      end
      if (cmd.release_lock) begin
        lock_held  <= 1'b0;
        owner_task <= '0;
        if (ring_count != '0) begin
          ring_head  <= ring_slot(ring_head, CNT_W'(1));
          ring_count <= count_dec;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.acquire || cmd.reject || cmd.rel_empty || cmd.rel_deq || cmd.query_done;
    end
  end

  // result payload; count fields reflect the state after the step
  always_ff @(posedge clk) begin
    if (cmd.acquire) begin
      result.next_valid    <= 1'b0;
      result.deq_task      <= '0;
      result.was_owner     <= owner_q;
      result.is_waiting    <= 1'b0;
      if (!lock_held) begin
        result.status        <= ST_GRANTED;
        result.waiting_total <= WTOTAL_W'(ring_count);
      end else if (!count_full) begin
        result.status        <= ST_QUEUED;
        result.waiting_total <= WTOTAL_W'(ring_count + CNT_W'(1));
      end else begin
        result.status        <= ST_DROPPED;
        result.waiting_total <= WTOTAL_W'(ring_count);
      end
    end else if (cmd.reject || cmd.rel_empty || cmd.query_done) begin
      result.next_valid    <= 1'b0;
      result.deq_task      <= '0;
      result.was_owner     <= owner_q;
      result.is_waiting    <= cmd.query_hit;
      result.waiting_total <= WTOTAL_W'(ring_count);
      if (cmd.reject) begin
        result.status <= ST_REJECTED;
      end else if (cmd.rel_empty) begin
        result.status <= ST_RELEASED;
      end else begin
        result.status <= ST_QUERIED;
      end
    end else if (cmd.rel_deq) begin
      // count already dropped when the lock was freed
      result.status        <= ST_RELEASED;
      result.next_valid    <= 1'b1;
      result.deq_task      <= TASK_W'(ram_rdata);
      result.was_owner     <= owner_q;
      result.is_waiting    <= 1'b0;
      result.waiting_total <= WTOTAL_W'(ring_count);
    end
  end

endmodule
`default_nettype wire

// File: src/fifo_wait_mutex_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fifo_wait_mutex_unit: single lock with a FIFO queue of waiting tasks
// Issue a command with start while busy is low; the result appears on result
// for one cycle with done high and must be taken then. Acquire, a rejected
// release, a release with no waiter and a query of an empty queue end in the
// execute state, a release that dequeues a waiter in the dequeue state, and
// done is registered after that state. A query reads the wait ring through its
// single read port one entry per cycle until it finds the task or reaches the
// last waiter. A new item may be issued in the cycle that done is high. The
// ring is not cleared after reset; it is only read inside its live count.
// ----------------------------------------------------------------------------
module fifo_wait_mutex_unit import fwmu_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      start,
  output logic           busy,
  input  wire fwmu_req_t request,
  output logic           done,
  output fwmu_res_t      result
);

  fwmu_cmd_t  cmd;
  fwmu_stat_t stat;

  fwmu_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  fwmu_dp u_dp (
    .clk     (clk),
    .rst     (rst),
    .request (request),
    .cmd     (cmd),
    .stat    (stat),
    .done    (done),
    .result  (result)
  );

endmodule
`default_nettype wire
